FILE: design/assert_macros.svh
// Assertion macros shared by the checker RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/lrc_pkg.sv
// Types, constants and helpers for the response frame checker.
// No dependencies.
package lrc_pkg;

   localparam int MAX_DATA_DEFAULT = 16;
   localparam int JOB_DEPTH        = 2;

   localparam logic [7:0] STATION_RESET = 8'h31;

   localparam logic [7:0] BYTE_ACK = 8'h06;
   localparam logic [7:0] BYTE_NAK = 8'h15;
   localparam logic [7:0] BYTE_ETX = 8'h03;

   localparam logic [7:0] REJ_A = 8'h61;
   localparam logic [7:0] REJ_B = 8'h62;
   localparam logic [7:0] REJ_C = 8'h63;
   localparam logic [7:0] REJ_E = 8'h65;
   localparam logic [7:0] REJ_H = 8'h68;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_DATA   = 1'b1;

   typedef enum logic [3:0] {
      ST_OK       = 4'd0,
      ST_TIMEOUT  = 4'd1,
      ST_ACK_BAD  = 4'd2,
      ST_ADDRESS  = 4'd3,
      ST_COMMAND  = 4'd4,
      ST_CHECK    = 4'd5,
      ST_NAK_A    = 4'd6,
      ST_NAK_B    = 4'd7,
      ST_NAK_C    = 4'd8,
      ST_NAK_E    = 4'd9,
      ST_NAK_H    = 4'd10,
      ST_NAK_UNK  = 4'd11,
      ST_OVERRUN  = 4'd12
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  reject;
      logic        has_data;
      logic        bank;
   } job_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  status;
      logic [7:0]  reject_code;
      logic [4:0]  data_count;
      logic [7:0]  data_byte;
      logic        last;
   } rsp_item_type;

   function automatic status_type nak_status(input logic [7:0] code);
      status_type st;
      case (code)
         REJ_A:   st = ST_NAK_A;
         REJ_B:   st = ST_NAK_B;
         REJ_C:   st = ST_NAK_C;
         REJ_E:   st = ST_NAK_E;
         REJ_H:   st = ST_NAK_H;
         default: st = ST_NAK_UNK;
      endcase
      return st;
   endfunction

endpackage

FILE: design/lrc_channels.sv
// Handshake channel interfaces: request bytes, response items, register write.
// No dependencies.
interface lrc_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] rx_byte;
   logic [7:0] expected_command;
   modport source (output valid, mode, rx_byte, expected_command, input ready);
   modport sink   (input valid, mode, rx_byte, expected_command, output ready);
endinterface

interface lrc_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [3:0] status;
   logic [7:0] reject_code;
   logic [4:0] data_count;
   logic [7:0] data_byte;
   logic       last;
   modport source (output valid, kind, status, reject_code, data_count, data_byte, last,
                   input ready);
   modport sink   (input valid, kind, status, reject_code, data_count, data_byte, last,
                   output ready);
endinterface

interface lrc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: design/lrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: design/lrc_job_fifo.sv
// Short queue of finished-frame jobs between the parser and the emitter.
// No dependencies.
module lrc_job_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty,
   output logic [CW-1:0]    count
);
   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + PW'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

   assign pop_data  = entry_ff[rptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;
endmodule

FILE: design/lrc_front.sv
// Frame parser: takes received bytes, tracks frame state, stores data bytes
// and pushes one job per finished frame. Depends on lrc_pkg and lrc_channels.
module lrc_front #(
   parameter int MAX_DATA = lrc_pkg::MAX_DATA_DEFAULT,
   localparam int AW      = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1,
   localparam int LW      = $clog2(MAX_DATA + 1)
) (
   input  logic               clock,
   input  logic               reset,
   lrc_req_if.sink            req,
   input  logic [7:0]         station_address,
   input  logic               slot_free,
   output logic               ram_we,
   output logic [AW:0]        ram_waddr,
   output logic [7:0]         ram_wdata,
   output logic               job_push,
   output lrc_pkg::job_type   job,
   output logic [LW-1:0]      job_length
);
   import lrc_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_BODY  = 3'b010,
      PH_CHECK = 3'b100
   } phase_type;

   localparam logic [1:0] POS_ADDR = 2'd1;
   localparam logic [1:0] POS_CMD  = 2'd2;
   localparam logic [1:0] POS_DATA = 2'd3;

   phase_type     phase_ff, phase_in;
   logic [1:0]    pos_ff, pos_in;
   logic [7:0]    xor_ff, xor_in;
   logic [7:0]    first_ff, first_in;
   logic          addr_ok_ff, addr_ok_in;
   logic          cmd_ok_ff, cmd_ok_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [7:0]    rej_ff, rej_in;
   logic [LW-1:0] len_ff, len_in;
   logic          ovr_ff, ovr_in;
   logic          bank_ff, bank_in;

   logic          accept;
   logic          cut;
   logic          finish;
   logic [7:0]    b;
   status_type    st;
   logic [7:0]    rej_out;
   logic          room;

   assign req.ready = slot_free;
   assign accept    = req.valid && slot_free;
   assign b         = req.rx_byte;
   assign cut       = req.mode || ((phase_ff != PH_CHECK) && (b == 8'h00));
   assign finish    = accept && (cut || (phase_ff == PH_CHECK));
   assign room      = (len_ff < LW'(MAX_DATA));

   // Frame-end status in priority order
   always_comb begin
      rej_out = 8'h00;
      if (cut) begin
         st = ST_TIMEOUT;
      end else if (ovr_ff) begin
         st = ST_OVERRUN;
      end else if (first_ff != BYTE_ACK) begin
         if (first_ff == BYTE_NAK) begin
            rej_out = rej_ff;
            st      = nak_status(rej_ff);
         end else begin
            st = ST_ACK_BAD;
         end
      end else if (!addr_ok_ff) begin
         st = ST_ADDRESS;
      end else if (!cmd_ok_ff) begin
         st = ST_COMMAND;
      end else if (b != xor_ff) begin
         st = ST_CHECK;
      end else begin
         st = ST_OK;
      end
   end

   assign job_push     = finish;
   assign job.status   = st;
   assign job.reject   = rej_out;
   assign job.has_data = (st == ST_OK) && (len_ff != '0);
   assign job.bank     = bank_ff;
   assign job_length   = len_ff;

   assign ram_we    = accept && !cut && (phase_ff == PH_BODY) && (b != BYTE_ETX)
                      && (pos_ff == POS_DATA) && room;
   assign ram_waddr = {bank_ff, len_ff[AW-1:0]};
   assign ram_wdata = b;

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      xor_in     = xor_ff;
      first_in   = first_ff;
      addr_ok_in = addr_ok_ff;
      cmd_ok_in  = cmd_ok_ff;
      cmd_in     = cmd_ff;
      rej_in     = rej_ff;
      len_in     = len_ff;
      ovr_in     = ovr_ff;
      bank_in    = bank_ff;
      if (finish) begin
         // drop the frame state; next frame goes to the other bank
         phase_in   = PH_IDLE;
         pos_in     = '0;
         xor_in     = '0;
         first_in   = '0;
         addr_ok_in = 1'b0;
         cmd_ok_in  = 1'b0;
         cmd_in     = '0;
         rej_in     = '0;
         len_in     = '0;
         ovr_in     = 1'b0;
         bank_in    = !bank_ff;
      end else if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               first_in = b;
               cmd_in   = req.expected_command;
               xor_in   = b;
               phase_in = (b == BYTE_ETX) ? PH_CHECK : PH_BODY;
               pos_in   = POS_ADDR;
            end
            PH_BODY: begin
               xor_in = xor_ff ^ b;
               if ((pos_ff == POS_DATA) && (len_ff == '0) && !ovr_ff) begin
                  rej_in = b;
               end
               if (b == BYTE_ETX) begin
                  phase_in = PH_CHECK;
               end else if (pos_ff == POS_ADDR) begin
                  addr_ok_in = (b == station_address);
                  pos_in     = POS_CMD;
               end else if (pos_ff == POS_CMD) begin
                  cmd_ok_in = (b == cmd_ff);
                  pos_in    = POS_DATA;
               end else if (room) begin
                  len_in = len_ff + LW'(1);
               end else begin
                  ovr_in = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         pos_ff     <= '0;
         xor_ff     <= '0;
         first_ff   <= '0;
         addr_ok_ff <= 1'b0;
         cmd_ok_ff  <= 1'b0;
         cmd_ff     <= '0;
         rej_ff     <= '0;
         len_ff     <= '0;
         ovr_ff     <= 1'b0;
         bank_ff    <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         xor_ff     <= xor_in;
         first_ff   <= first_in;
         addr_ok_ff <= addr_ok_in;
         cmd_ok_ff  <= cmd_ok_in;
         cmd_ff     <= cmd_in;
         rej_ff     <= rej_in;
         len_ff     <= len_in;
         ovr_ff     <= ovr_in;
         bank_ff    <= bank_in;
      end
   end
endmodule

FILE: design/lrc_back.sv
// Result emitter: pops frame jobs, sends the status item, then reads the
// stored data bytes out of the RAM. Depends on lrc_pkg and lrc_channels.
module lrc_back #(
   parameter int MAX_DATA = lrc_pkg::MAX_DATA_DEFAULT,
   localparam int AW      = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1,
   localparam int LW      = $clog2(MAX_DATA + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  lrc_pkg::job_type   job,
   input  logic [LW-1:0]      job_length,
   output logic               job_pop,
   output logic [AW:0]        ram_raddr,
   input  logic [7:0]         ram_rdata,
   lrc_rsp_if.source          rsp,
   output logic               busy
);
   import lrc_pkg::*;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_WAIT = 3'b010,
      B_DATA = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [LW-1:0]  len_ff, len_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic           bank_ff, bank_in;
   rsp_item_type   out_ff, out_in;
   logic           out_valid_ff, out_valid_in;

   logic           out_free;
   logic           is_last;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign is_last   = ((LW'(idx_ff) + LW'(1)) == len_ff);
   assign ram_raddr = {bank_ff, idx_ff};
   assign busy      = (state_ff != B_IDLE);
   assign job_pop   = (state_ff == B_IDLE) && job_valid && out_free;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      bank_in      = bank_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      unique case (state_ff)
         B_IDLE: begin
            if (job_pop) begin
               out_in.kind        = KIND_STATUS;
               out_in.status      = job.status;
               out_in.reject_code = job.reject;
               out_in.data_count  = 5'(job_length);
               out_in.data_byte   = 8'h00;
               out_in.last        = !job.has_data;
               out_valid_in       = 1'b1;
               if (job.has_data) begin
                  len_in   = job_length;
                  idx_in   = '0;
                  bank_in  = job.bank;
                  state_in = B_WAIT;
               end
            end
         end
         B_WAIT: begin
            // read data for idx_ff lands in the RAM output register
            state_in = B_DATA;
         end
         B_DATA: begin
            if (out_free) begin
               out_in.kind        = KIND_DATA;
               out_in.status      = ST_OK;
               out_in.reject_code = 8'h00;
               out_in.data_count  = 5'(len_ff);
               out_in.data_byte   = ram_rdata;
               out_in.last        = is_last;
               out_valid_in       = 1'b1;
               if (is_last) begin
                  state_in = B_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = B_WAIT;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      idx_ff  <= idx_in;
      bank_ff <= bank_in;
      out_ff  <= out_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.kind        = out_ff.kind;
   assign rsp.status      = out_ff.status;
   assign rsp.reject_code = out_ff.reject_code;
   assign rsp.data_count  = out_ff.data_count;
   assign rsp.data_byte   = out_ff.data_byte;
   assign rsp.last        = out_ff.last;
endmodule

FILE: design/lrc_response_frame_checker.sv
// Response frame checker: one received byte or timeout event per transaction.
// Throughput: one byte per cycle while fewer than two finished frames await output.
// Output: the frame-ending byte queues a job; the emitter pops it into the registered
//   status item, then each data byte follows through a registered RAM read per byte.
// Reset: synchronous, active high; clears frame state and queue, address 0x31.
//   Data RAM is not cleared: only bytes written in the current frame are read.
`include "assert_macros.svh"

module lrc_response_frame_checker #(
   parameter int MAX_DATA = lrc_pkg::MAX_DATA_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   lrc_req_if.sink    req_ch,
   lrc_rsp_if.source  rsp_ch,
   lrc_csr_if.sink    csr_ch
);
   import lrc_pkg::*;

   localparam int AW     = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
   localparam int LW     = $clog2(MAX_DATA + 1);
   localparam int JW     = $bits(job_type) + LW;
   localparam int CW     = $clog2(JOB_DEPTH + 1);
   // two banks: the front fills one while the back drains the other
   localparam int RAM_DEPTH = 2 ** (AW + 1);

   logic [7:0]    station_ff, station_in;

   logic          ram_we;
   logic [AW:0]   ram_waddr;
   logic [7:0]    ram_wdata;
   logic [AW:0]   ram_raddr;
   logic [7:0]    ram_rdata;

   logic          job_push;
   job_type       front_job;
   logic [LW-1:0] front_length;
   logic          job_pop;
   job_type       back_job;
   logic [LW-1:0] back_length;
   logic [JW-1:0] pop_data;
   logic          job_valid;
   logic [CW-1:0] job_count;
   logic          back_busy;
   logic          slot_free;

   // Station address register; writes always taken
   assign csr_ch.ready = 1'b1;
   assign station_in   = csr_ch.valid ? csr_ch.data : station_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff <= STATION_RESET;
      end else begin
         station_ff <= station_in;
      end
   end

   // Hold off new bytes once two frames are pending (queued or draining),
   // so the bank being filled is never the one being read.
   assign slot_free = (job_count == '0) || ((job_count == CW'(1)) && !back_busy);

   lrc_front #(.MAX_DATA(MAX_DATA)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req             (req_ch),
      .station_address (station_ff),
      .slot_free       (slot_free),
      .ram_we          (ram_we),
      .ram_waddr       (ram_waddr),
      .ram_wdata       (ram_wdata),
      .job_push        (job_push),
      .job             (front_job),
      .job_length      (front_length)
   );

   lrc_job_fifo #(.WIDTH(JW), .DEPTH(JOB_DEPTH)) u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({front_length, front_job}),
      .pop       (job_pop),
      .pop_data  (pop_data),
      .not_empty (job_valid),
      .count     (job_count)
   );

   assign {back_length, back_job} = pop_data;

   lrc_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_data_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   lrc_back #(.MAX_DATA(MAX_DATA)) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job        (back_job),
      .job_length (back_length),
      .job_pop    (job_pop),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .rsp        (rsp_ch),
      .busy       (back_busy)
   );

   // queue never overflows
   `ASSERT_IMPLIES(a_fifo_no_overflow, clock, reset, job_push && !job_pop, job_count != CW'(JOB_DEPTH))
   // filling never touches the bank being drained
   `ASSERT_IMPLIES(a_bank_split, clock, reset, ram_we && back_busy, ram_waddr[AW] != ram_raddr[AW])
   // data items only carry an ok status
   `ASSERT_IMPLIES(a_data_status_ok, clock, reset, rsp_ch.valid && (rsp_ch.kind == KIND_DATA), rsp_ch.status == 4'(ST_OK))
endmodule
